// File: rtl/core/dimqm_pkg.sv
// Shared constants and types for the depth image quad mesh block.
// Depends on nothing; the top level and the vertex pipeline refer to it by scoped names.
`timescale 1ns / 1ps
package dimqm_pkg;
  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;
  localparam int COL_W = $clog2(IMAGE_WIDTH);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT);
  localparam int U_W   = $clog2(IMAGE_WIDTH + 1);
  localparam int V_W   = $clog2(IMAGE_HEIGHT + 1);
  localparam int NUM_W = 17;
  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 24;
  localparam int XY_W    = 22;
  localparam int Z_W     = 17;
  localparam int RECIP_W = 24;
  localparam int CTR_W   = 14;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RECIP_X = 3'd0;
  localparam logic [2:0] CFG_RECIP_Y = 3'd1;
  localparam logic [2:0] CFG_CTR_COL = 3'd2;
  localparam logic [2:0] CFG_CTR_ROW = 3'd3;
  localparam logic [2:0] CFG_THRESH  = 3'd4;

  // One vertex to be projected.
  typedef struct packed {
    logic [U_W-1:0]     u;
    logic [V_W-1:0]     v;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] color;
    logic               last;
  } vtx_t;
endpackage

// File: rtl/core/dimqm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module dimqm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 640
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/dimqm_vertex_pipe.sv
// Three-stage projection pipeline: offset times depth, split multiply by the
// focal reciprocal, then round and saturate into the output register. Uses dimqm_pkg.
`timescale 1ns / 1ps
module dimqm_vertex_pipe (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vtx_valid,
  input  dimqm_pkg::vtx_t                   vtx,
  output logic                              adv,
  input  logic [dimqm_pkg::RECIP_W-1:0]     recip_x,
  input  logic [dimqm_pkg::RECIP_W-1:0]     recip_y,
  input  logic [dimqm_pkg::CTR_W-1:0]       center_col,
  input  logic [dimqm_pkg::CTR_W-1:0]       center_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dimqm_pkg::XY_W-1:0] out_vert_x,
  output logic signed [dimqm_pkg::XY_W-1:0] out_vert_y,
  output logic signed [dimqm_pkg::Z_W-1:0]  out_vert_z,
  output logic [7:0]                        out_chan_a,
  output logic [7:0]                        out_chan_b,
  output logic [7:0]                        out_chan_c,
  output logic                              out_run_last
);
  localparam int P1_W = dimqm_pkg::NUM_W + 17;
  localparam int P2_W = P1_W + 13;
  localparam int S_W  = P2_W + 13;

  logic v1_r, v2_r, ov_r;
  logic signed [P1_W-1:0] p1x_r, p1y_r;
  logic signed [P2_W-1:0] pxl_r, pxh_r, pyl_r, pyh_r;
  logic [dimqm_pkg::DEPTH_W-1:0] d1_r, d2_r;
  logic [dimqm_pkg::COLOR_W-1:0] c1_r, c2_r;
  logic l1_r, l2_r;
  logic signed [dimqm_pkg::NUM_W-1:0] num_x, num_y;
  logic signed [S_W-1:0] sx, sy;
  logic signed [31:0] rx, ry;
  logic signed [dimqm_pkg::XY_W-1:0] satx, saty;

  assign adv = !(ov_r && out_stall);
  assign out_valid = ov_r;

  always_comb begin
    num_x = $signed({{(dimqm_pkg::NUM_W - 4 - dimqm_pkg::U_W){1'b0}}, vtx.u, 4'b0000})
          - $signed({{(dimqm_pkg::NUM_W - dimqm_pkg::CTR_W){1'b0}}, center_col});
    num_y = $signed({{(dimqm_pkg::NUM_W - 4 - dimqm_pkg::V_W){1'b0}}, vtx.v, 4'b0000})
          - $signed({{(dimqm_pkg::NUM_W - dimqm_pkg::CTR_W){1'b0}}, center_row});
    // Round half up, then floor through the arithmetic shift.
    sx = (S_W'(pxh_r) <<< 12) + S_W'(pxl_r) + (S_W'(1) <<< 27);
    sy = (S_W'(pyh_r) <<< 12) + S_W'(pyl_r) + (S_W'(1) <<< 27);
    rx = 32'(sx >>> 28);
    ry = 32'(sy >>> 28);
    if (rx > 32'sd2097151) satx = 22'sd2097151;
    else if (rx < -32'sd2097152) satx = -22'sd2097152;
    else satx = rx[dimqm_pkg::XY_W-1:0];
    if (ry > 32'sd2097151) saty = 22'sd2097151;
    else if (ry < -32'sd2097152) saty = -22'sd2097152;
    else saty = ry[dimqm_pkg::XY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vtx_valid;
      v2_r <= v1_r;
      ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1x_r <= num_x * $signed({1'b0, vtx.depth});
      p1y_r <= num_y * $signed({1'b0, vtx.depth});
      d1_r  <= vtx.depth;
      c1_r  <= vtx.color;
      l1_r  <= vtx.last;
      pxl_r <= p1x_r * $signed({1'b0, recip_x[11:0]});
      pxh_r <= p1x_r * $signed({1'b0, recip_x[23:12]});
      pyl_r <= p1y_r * $signed({1'b0, recip_y[11:0]});
      pyh_r <= p1y_r * $signed({1'b0, recip_y[23:12]});
      d2_r  <= d1_r;
      c2_r  <= c1_r;
      l2_r  <= l1_r;
      out_vert_x   <= satx;
      out_vert_y   <= saty;
      out_vert_z   <= -$signed({1'b0, d2_r});
      out_chan_a   <= c2_r[7:0];
      out_chan_b   <= c2_r[15:8];
      out_chan_c   <= c2_r[23:16];
      out_run_last <= l2_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (ov_r && out_stall) |=> ov_r)
    else $error("output item lost while stalled");
  assert property (@(posedge clk) disable iff (!rst_n) !adv |=> $stable(out_vert_x))
    else $error("output moved while pipeline held");
  assert property (@(posedge clk) disable iff (!rst_n) (adv && v2_r) |=> ov_r)
    else $error("stage two item did not reach output");
endmodule

// File: rtl/core/depth_image_quad_mesh.sv
// Top level of the depth image quad mesh block: pixel sequencer, upper row
// depth memory and projection pipeline. Uses dimqm_pkg, dimqm_ram, dimqm_vertex_pipe.
`timescale 1ns / 1ps
// Usage:
// Pixels enter on the in_ channel in raster order, top row first, with
// in_frame_start on the first pixel of a frame. A pixel is emitted as a
// quad plus optional joins when its right neighbor arrives; the last pixel
// of a row is emitted on its own arrival. Vertices leave on the out_
// channel one per item, out_run_last marking the final vertex an input
// pixel caused. Configuration registers are to be written on the cfg_
// channel (always ready) only while the block is idle, which the block
// does not enforce. An input pixel is taken in the idle state; the block
// then reads the depth above the held pixel, then the one above the
// current pixel, then issues its vertices, up to 20, one per cycle while
// the receiver does not stall; no new pixel is taken until the last of
// them has been issued. An issued vertex is registered, then passes the
// offset product, reciprocal product and output registers of the
// pipeline. If the receiver stalls, the whole vertex pipeline holds and
// no new pixel is taken once the sequencer is blocked. Reset restores
// the register defaults and clears the position counters and held
// pixel; the depth memory needs no clearing pass.
module depth_image_quad_mesh (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       in_depth_mm,
  input  logic [7:0]                        in_chan_a,
  input  logic [7:0]                        in_chan_b,
  input  logic [7:0]                        in_chan_c,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dimqm_pkg::XY_W-1:0] out_vert_x,
  output logic signed [dimqm_pkg::XY_W-1:0] out_vert_y,
  output logic signed [dimqm_pkg::Z_W-1:0]  out_vert_z,
  output logic [7:0]                        out_chan_a,
  output logic [7:0]                        out_chan_b,
  output logic [7:0]                        out_chan_c,
  output logic                              out_run_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [23:0]                       cfg_data
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD1  = 4'b0010,
    ST_RD2  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // Vertex groups, four vertices each.
  localparam logic [2:0] GRP_HELD_QUAD  = 3'd0;
  localparam logic [2:0] GRP_HELD_RIGHT = 3'd1;
  localparam logic [2:0] GRP_HELD_UP    = 3'd2;
  localparam logic [2:0] GRP_CUR_QUAD   = 3'd3;
  localparam logic [2:0] GRP_CUR_UP     = 3'd4;

  localparam int W  = dimqm_pkg::IMAGE_WIDTH;
  localparam int H  = dimqm_pkg::IMAGE_HEIGHT;
  localparam int CW = dimqm_pkg::COL_W;
  localparam int RW = dimqm_pkg::ROW_W;
  localparam int DW = dimqm_pkg::DEPTH_W;

  state_t state_r, state_nxt;
  logic [23:0] recip_x_r, recip_y_r;
  logic [13:0] ctr_col_r, ctr_row_r;
  logic [15:0] thr_r;

  logic [CW-1:0] col_r, x_r;
  logic [RW-1:0] row_r;
  logic [DW-1:0] held_d_r, hd_r, cd_r, up1_r, up2_r;
  logic [23:0]   held_c_r, hc_r, cc_r;
  logic [dimqm_pkg::V_W-1:0] yf_r;
  logic has_up_r, eh_r, ec_r;
  logic [4:0] mask_r, mask_new, mask_rem;
  logic [2:0] grp_r, first_new, first_rem;
  logic [1:0] k_r;

  logic accept, adv;
  logic [CW-1:0] x_in;
  logic [RW-1:0] row_in;
  logic [DW-1:0] held_in;
  logic [23:0]   heldc_in;

  logic          ram_we;
  logic [CW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  dimqm_pkg::vtx_t vtx_r, vtx_nxt;
  logic vtx_v_r;

  function automatic logic joins(input logic [15:0] d, input logic [15:0] o,
                                 input logic [15:0] thr);
    logic [15:0] diff;
    begin
      diff = (d > o) ? d - o : o - d;
      return (o != 16'd0) && (diff < thr);
    end
  endfunction

  function automatic logic [2:0] first_set(input logic [4:0] m);
    logic [2:0] g;
    begin
      g = GRP_CUR_UP;
      for (int i = 4; i >= 0; i--) begin
        if (m[i]) g = 3'(i);
      end
      return g;
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    x_in     = in_frame_start ? '0 : col_r;
    row_in   = in_frame_start ? '0 : row_r;
    held_in  = in_frame_start ? '0 : held_d_r;
    heldc_in = in_frame_start ? '0 : held_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_x_r <= 24'd31957;
      recip_y_r <= 24'd31957;
      ctr_col_r <= 14'd5120;
      ctr_row_r <= 14'd3840;
      thr_r     <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dimqm_pkg::CFG_RECIP_X: recip_x_r <= cfg_data;
        dimqm_pkg::CFG_RECIP_Y: recip_y_r <= cfg_data;
        dimqm_pkg::CFG_CTR_COL: ctr_col_r <= cfg_data[13:0];
        dimqm_pkg::CFG_CTR_ROW: ctr_row_r <= cfg_data[13:0];
        dimqm_pkg::CFG_THRESH:  thr_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Upper row depth memory: read above the held pixel on accept, above the
  // current pixel in the cycle after, writing each entry after it has been read.
  always_comb begin
    ram_raddr = x_in - CW'(1);
    ram_we    = 1'b0;
    ram_waddr = x_r - CW'(1);
    ram_wdata = hd_r;
    if (state_r == ST_RD1) begin
      ram_raddr = x_r;
      ram_we    = eh_r;
    end else if (state_r == ST_RD2) begin
      ram_we    = ec_r;
      ram_waddr = x_r;
      ram_wdata = cd_r;
    end
  end

  dimqm_ram #(.WIDTH(DW), .DEPTH(W)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    mask_new[GRP_HELD_QUAD]  = eh_r && (hd_r != '0);
    mask_new[GRP_HELD_RIGHT] = mask_new[GRP_HELD_QUAD] && joins(hd_r, cd_r, thr_r);
    mask_new[GRP_HELD_UP]    = mask_new[GRP_HELD_QUAD] && has_up_r
                               && joins(hd_r, up1_r, thr_r);
    mask_new[GRP_CUR_QUAD]   = ec_r && (cd_r != '0);
    mask_new[GRP_CUR_UP]     = mask_new[GRP_CUR_QUAD] && has_up_r
                               && joins(cd_r, ram_rdata, thr_r);
    first_new = first_set(mask_new);
    mask_rem  = mask_r & ~(5'd1 << grp_r);
    first_rem = first_set(mask_rem);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = (mask_new != '0) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (adv && k_r == 2'd3 && mask_rem == '0) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Vertex descriptor for the current group and corner.
  always_comb begin
    logic [CW-1:0] base;
    logic du, dv, other;
    logic [DW-1:0] d_self, d_other;
    base    = (grp_r < GRP_CUR_QUAD) ? x_r - CW'(1) : x_r;
    d_self  = (grp_r < GRP_CUR_QUAD) ? hd_r : cd_r;
    d_other = (grp_r == GRP_HELD_RIGHT) ? cd_r :
              (grp_r == GRP_HELD_UP) ? up1_r : up2_r;
    du = 1'b0; dv = 1'b0; other = 1'b0;
    case (grp_r)
      GRP_HELD_RIGHT: begin
        du = 1'b1;
        dv = (k_r == 2'd1) || (k_r == 2'd2);
        other = (k_r == 2'd0) || (k_r == 2'd1);
      end
      GRP_HELD_UP, GRP_CUR_UP: begin
        du = (k_r == 2'd1) || (k_r == 2'd2);
        dv = 1'b1;
        other = (k_r == 2'd2) || (k_r == 2'd3);
      end
      default: begin
        du = (k_r == 2'd0) || (k_r == 2'd1);
        dv = (k_r == 2'd1) || (k_r == 2'd2);
      end
    endcase
    vtx_nxt.u     = dimqm_pkg::U_W'(base) + dimqm_pkg::U_W'(du);
    vtx_nxt.v     = yf_r + dimqm_pkg::V_W'(dv);
    vtx_nxt.depth = other ? d_other : d_self;
    vtx_nxt.color = (grp_r < GRP_CUR_QUAD) ? hc_r : cc_r;
    vtx_nxt.last  = (k_r == 2'd3) && (mask_rem == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      held_d_r <= '0;
      held_c_r <= '0;
      vtx_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) vtx_v_r <= (state_r == ST_EMIT);
      if (accept) begin
        if (x_in == CW'(W - 1)) begin
          col_r    <= '0;
          row_r    <= (row_in == RW'(H - 1)) ? '0 : row_in + RW'(1);
          held_d_r <= '0;
          held_c_r <= '0;
        end else begin
          col_r    <= x_in + CW'(1);
          row_r    <= row_in;
          held_d_r <= in_depth_mm;
          held_c_r <= {in_chan_c, in_chan_b, in_chan_a};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= x_in;
      yf_r     <= dimqm_pkg::V_W'(H - 1) - dimqm_pkg::V_W'(row_in);
      has_up_r <= (row_in != '0);
      eh_r     <= (x_in != '0);
      ec_r     <= (x_in == CW'(W - 1));
      hd_r     <= held_in;
      hc_r     <= heldc_in;
      cd_r     <= in_depth_mm;
      cc_r     <= {in_chan_c, in_chan_b, in_chan_a};
    end
    if (state_r == ST_RD1) up1_r <= ram_rdata;
    if (state_r == ST_RD2) begin
      mask_r <= mask_new;
      grp_r  <= first_new;
      k_r    <= 2'd0;
      up2_r  <= ram_rdata;
    end
    if (state_r == ST_EMIT && adv) begin
      k_r <= k_r + 2'd1;
      if (k_r == 2'd3) begin
        mask_r <= mask_rem;
        grp_r  <= first_rem;
      end
    end
    if (adv) vtx_r <= vtx_nxt;
  end

  dimqm_vertex_pipe u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .vtx_valid    (vtx_v_r),
    .vtx          (vtx_r),
    .adv          (adv),
    .recip_x      (recip_x_r),
    .recip_y      (recip_y_r),
    .center_col   (ctr_col_r),
    .center_row   (ctr_row_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_vert_x   (out_vert_x),
    .out_vert_y   (out_vert_y),
    .out_vert_z   (out_vert_z),
    .out_chan_a   (out_chan_a),
    .out_chan_b   (out_chan_b),
    .out_chan_c   (out_chan_c),
    .out_run_last (out_run_last)
  );

  assert property (@(posedge clk) disable iff (!rst_n) accept |=> state_r == ST_RD1)
    else $error("accepted item did not start a memory read");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_EMIT) |-> mask_r != '0)
    else $error("emitting with no group pending");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_EMIT) |-> mask_r[grp_r])
    else $error("current group not pending");
endmodule
